[rtl/sfj_pkg.sv]
`timescale 1ns / 1ps
package sfj_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int FOOTER_POS   = FRAME_BYTES - 1;
    localparam int FLAG_POS     = 23;
    localparam int CH_COUNT     = 16;
    localparam int CH_WIDTH     = 11;
    localparam int CH_BITS      = CH_COUNT * CH_WIDTH;
    localparam int NUM_RESULTS  = 16;
    localparam int AXIS_SLOTS   = 10;
    localparam int GEAR_RESULT  = 10;
    localparam int CENTER       = 1000;
    localparam int SPAN         = 720;
    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;

    localparam logic [10:0] GEAR_LIM1 = 11'd440;
    localparam logic [10:0] GEAR_LIM2 = 11'd760;
    localparam logic [10:0] GEAR_LIM3 = 11'd1000;
    localparam logic [10:0] GEAR_LIM4 = 11'd1200;
    localparam logic [10:0] GEAR_LIM5 = 11'd1520;

    typedef enum logic [1:0] {
        CFG_HEADER = 2'd0,
        CFG_ALT    = 2'd1,
        CFG_FOOTER = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               lost;
        logic               failsafe;
        logic [CH_BITS-1:0] ch;
    } frame_t;

    function automatic logic [3:0] axis_channel(input logic [3:0] slot);
        logic [3:0] ch;
        case (slot)
            4'd0:    ch = 4'd1;
            4'd1:    ch = 4'd0;
            4'd2:    ch = 4'd2;
            4'd3:    ch = 4'd3;
            4'd4:    ch = 4'd5;
            4'd5:    ch = 4'd6;
            4'd6:    ch = 4'd7;
            4'd7:    ch = 4'd8;
            4'd8:    ch = 4'd9;
            4'd9:    ch = 4'd10;
            default: ch = 4'd0;
        endcase
        return ch;
    endfunction

endpackage

[rtl/sbus_frame_to_joystick.sv]
`timescale 1ns / 1ps
// Channel  Direction  Beat contents
// s_*      in         tdata[7:0] rx_byte
// m_*      out        tuser is_button; tdata slot, value, link_lost, failsafe; tlast last
// cfg_*    in         cfg_index register, cfg_data value
//
// One byte is taken per cycle while the frame buffer is filling and the queue is not full.
// A footer mismatch stalls input while the buffer shifts to a header.
// Each result passes through the prep, multiply and correct steps of the shared axis unit; a
// frame gives 16 results, subject to output stalls; a two-frame queue lets input run.
// Reset clears the fill count, queue, and output valid; the frame buffer needs no clearing.
module sbus_frame_to_joystick
    import sfj_pkg::*;
#(
    parameter int AXIS_FRAC_BITS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] slot, [19:4] value, [20] link_lost, [21] failsafe
    output logic        m_tuser,   // [0] is_button
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic   q_full, push, pop, head_valid;
    frame_t push_frame, head;

    sfj_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_frame (push_frame)
    );

    sfj_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sfj_back #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/sfj_front.sv]
`timescale 1ns / 1ps
module sfj_front
    import sfj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output logic       push,
    output frame_t     push_frame
);

    typedef enum logic {F_RUN, F_SHIFT} fstate_t;

    fstate_t     state_reg, state_next;
    logic [4:0]  count_reg, count_next;
    logic [7:0]  hdr_reg, alt_reg, foot_reg;
    logic [7:0]  buf_reg  [FRAME_BYTES];
    logic [7:0]  buf_next [FRAME_BYTES];
    logic        accept;
    logic        in_hdr, shift_hdr;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == F_RUN) && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign in_hdr    = (s_tdata == hdr_reg) || (s_tdata == alt_reg);
    assign shift_hdr = (buf_reg[1] == hdr_reg) || (buf_reg[1] == alt_reg);

    always_comb
    begin
        for (int j = 0; j < CH_BITS / 8; j++)
        begin
            push_frame.ch[j*8 +: 8] = buf_reg[j+1];
        end
        push_frame.lost     = buf_reg[FLAG_POS][LOST_BIT];
        push_frame.failsafe = buf_reg[FLAG_POS][FAILSAFE_BIT];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        buf_next   = buf_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_RUN:
            begin
                if (accept && (count_reg != 5'd0 || in_hdr))
                begin
                    if (count_reg == 5'(FOOTER_POS))
                    begin
                        if (s_tdata == foot_reg)
                        begin
                            push       = 1'b1;
                            count_next = 5'd0;
                        end
                        else
                        begin
                            buf_next[FOOTER_POS] = s_tdata;
                            count_next           = 5'(FRAME_BYTES);
                            state_next           = F_SHIFT;
                        end
                    end
                    else
                    begin
                        buf_next[count_reg] = s_tdata;
                        count_next          = count_reg + 5'd1;
                    end
                end
            end
            F_SHIFT:
            begin
                for (int j = 0; j < FRAME_BYTES - 1; j++)
                begin
                    buf_next[j] = buf_reg[j+1];
                end
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd1 || shift_hdr)
                begin
                    state_next = F_RUN;
                end
            end
            default:
            begin
                state_next = F_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_RUN;
            count_reg <= 5'd0;
            hdr_reg   <= 8'h0F;
            alt_reg   <= 8'hF0;
            foot_reg  <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEADER: hdr_reg  <= cfg_data;
                    CFG_ALT:    alt_reg  <= cfg_data;
                    CFG_FOOTER: foot_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

[rtl/sfj_fifo.sv]
`timescale 1ns / 1ps
module sfj_fifo
    import sfj_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output frame_t head
);

    frame_t     mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_frame;
        end
    end

endmodule

[rtl/sfj_back.sv]
`timescale 1ns / 1ps
module sfj_back
    import sfj_pkg::*;
#(
    parameter int AXIS_FRAC_BITS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  frame_t      head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam longint unsigned RECIP = (64'd1 << (16 + AXIS_FRAC_BITS)) / 64'(SPAN);
    localparam int CW  = $clog2(RECIP + 1);
    localparam int PW  = 11 + CW;
    localparam int QW  = AXIS_FRAC_BITS + 1;
    localparam int NW  = 11 + AXIS_FRAC_BITS;
    localparam logic [QW-1:0] ONE = QW'(1) << AXIS_FRAC_BITS;

    typedef enum logic [1:0] {B_IDLE, B_PREP, B_MUL, B_FIN} bstate_t;

    bstate_t         state_reg;
    logic [3:0]      idx_reg;
    logic [10:0]     x_reg;
    logic            neg_reg;
    logic            btn_reg;
    logic [2:0]      bval_reg;
    logic [3:0]      slot_reg;
    logic [QW-1:0]   q0_reg;
    logic [23:0]     data_reg;
    logic            user_reg, last_reg, valid_reg;

    logic [3:0]      ch_sel;
    logic [10:0]     raw;
    logic signed [11:0] d;
    logic [2:0]      gear;
    logic [PW-1:0]   prod;
    logic [NW-1:0]   rem;
    logic [QW-1:0]   mag;
    logic [16:0]     mag_ext;
    logic [15:0]     axis_val;
    logic [15:0]     out_val;
    logic            out_free;

    assign ch_sel = (idx_reg < 4'(AXIS_SLOTS)) ? axis_channel(idx_reg) :
                    (idx_reg == 4'(GEAR_RESULT)) ? 4'd4 : idx_reg;
    assign raw    = head.ch[ch_sel*CH_WIDTH +: CH_WIDTH];
    assign d      = $signed({1'b0, raw}) - 12'sd1000;

    always_comb
    begin
        if (raw < GEAR_LIM1)      gear = 3'd1;
        else if (raw < GEAR_LIM2) gear = 3'd2;
        else if (raw < GEAR_LIM3) gear = 3'd3;
        else if (raw < GEAR_LIM4) gear = 3'd4;
        else if (raw < GEAR_LIM5) gear = 3'd5;
        else                      gear = 3'd6;
    end

    assign prod = PW'(x_reg) * PW'(CW'(RECIP));
    assign rem  = {x_reg, {AXIS_FRAC_BITS{1'b0}}} - NW'(q0_reg) * NW'(SPAN);

    always_comb
    begin
        if (x_reg >= 11'(SPAN))
            mag = ONE;
        else if (rem >= NW'(SPAN))
            mag = q0_reg + QW'(1);
        else
            mag = q0_reg;
        mag_ext = 17'(mag);
        if (neg_reg)
            axis_val = 16'(17'd0 - mag_ext);
        else if (mag_ext > 17'd32767)
            axis_val = 16'd32767;
        else
            axis_val = mag_ext[15:0];
        out_val = btn_reg ? {13'd0, bval_reg} : axis_val;
    end

    assign out_free = !valid_reg || m_tready;
    assign pop      = (state_reg == B_FIN) && out_free && (idx_reg == 4'(NUM_RESULTS - 1));
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_FIN && out_free)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    idx_reg <= 4'd0;
                    if (head_valid)
                    begin
                        state_reg <= B_PREP;
                    end
                end
                B_PREP:  state_reg <= B_MUL;
                B_MUL:   state_reg <= B_FIN;
                B_FIN:
                begin
                    if (out_free)
                    begin
                        if (idx_reg == 4'(NUM_RESULTS - 1))
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= B_PREP;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_PREP)
        begin
            x_reg    <= d[11] ? 11'(-d) : d[10:0];
            neg_reg  <= d[11] ^ (idx_reg == 4'd0);
            btn_reg  <= (idx_reg >= 4'(AXIS_SLOTS));
            bval_reg <= (idx_reg == 4'(GEAR_RESULT)) ? gear :
                        {2'b00, raw > 11'(CENTER)};
            slot_reg <= (idx_reg < 4'(AXIS_SLOTS)) ? idx_reg : idx_reg - 4'(GEAR_RESULT);
        end
        if (state_reg == B_MUL)
        begin
            q0_reg <= prod[16 +: QW];
        end
        if (state_reg == B_FIN && out_free)
        begin
            data_reg <= {2'b00, head.failsafe, head.lost, out_val, slot_reg};
            user_reg <= btn_reg;
            last_reg <= (idx_reg == 4'(NUM_RESULTS - 1));
        end
    end

endmodule

[rtl/sfj_checker.sv]
`timescale 1ns / 1ps
module sfj_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped while stalled");

    a_last_btn: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser && m_tdata[3:0] == 4'd5)
        else $error("last beat is not the final button");

    a_axis_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[3:0] <= 4'd9)
        else $error("axis slot out of range");

    a_btn_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tdata[3:0] != 4'd0 |-> m_tdata[19:5] == 15'd0)
        else $error("button value not 0 or 1");

endmodule

bind sbus_frame_to_joystick sfj_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
